### rtl/mvsf_pkg.sv
// shared types, codes and helpers for the memory value search filter
// no dependencies
package mvsf_pkg;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_SNAP  = 2'd1,
        FUNC_CMP   = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REL_EQ = 3'd0,
        REL_LT = 3'd1,
        REL_LE = 3'd2,
        REL_GT = 3'd3,
        REL_GE = 3'd4,
        REL_NE = 3'd5
    } rel_t;

    typedef enum logic [1:0] {
        MODE_NIBBLE = 2'd0,
        MODE_BYTE   = 2'd1,
        MODE_HALF   = 2'd2,
        MODE_WORD   = 2'd3
    } size_mode_t;

    localparam logic [1:0] REG_SIZE_MODE = 2'd0;
    localparam logic [1:0] REG_USE_LAST  = 2'd1;
    localparam logic [1:0] REG_BANK_SIZE = 2'd2;

    localparam logic [1:0]  SIZE_MODE_RST = 2'd2;
    localparam logic        USE_LAST_RST  = 1'b1;
    localparam logic [16:0] BANK_SIZE_RST = 17'd65536;

    // index of the last byte of one entry
    function automatic logic [1:0] last_byte(input logic [1:0] mode);
        unique case (mode)
            MODE_HALF: last_byte = 2'd1;
            MODE_WORD: last_byte = 2'd3;
            default:   last_byte = 2'd0;
        endcase
    endfunction

    // log2 of the address step between entries
    function automatic logic [1:0] step_shift(input logic [1:0] mode);
        unique case (mode)
            MODE_HALF: step_shift = 2'd1;
            MODE_WORD: step_shift = 2'd2;
            default:   step_shift = 2'd0;
        endcase
    endfunction

endpackage

### rtl/mvsf_shadow_ram.sv
// byte-wide shadow copy of target ram, one write and one registered read port
// depends on nothing
module mvsf_shadow_ram #(
    parameter int AW = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/mvsf_cand_store.sv
// candidate list memory, entry = {address, upper flag, last-known value}
// depends on nothing
module mvsf_cand_store #(
    parameter int CW = 17,
    parameter int DW = 49
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [CW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [CW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**CW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/mvsf_rel_unit.sv
// shared unsigned relation unit used by every compare step
// depends on mvsf_pkg
module mvsf_rel_unit (
    input  logic [2:0]  kind,
    input  logic [31:0] x,
    input  logic [31:0] y,
    output logic        pass
);
    import mvsf_pkg::*;

    always_comb begin
        unique case (kind)
            REL_EQ:  pass = (x == y);
            REL_LT:  pass = (x < y);
            REL_LE:  pass = (x <= y);
            REL_GT:  pass = (x > y);
            REL_GE:  pass = (x >= y);
            REL_NE:  pass = (x != y);
            default: pass = 1'b0;
        endcase
    end
endmodule

### rtl/memory_value_search_filter_unit.sv
// top level of the memory value search filter: sequencer, registers, channels
// depends on mvsf_pkg, mvsf_shadow_ram, mvsf_cand_store, mvsf_rel_unit
//
// usage
//   input stream s_*: tuser carries the function code, tdata the operands.
//   functions: write one shadow ram byte, snapshot (build candidate list),
//   compare (filter list against live ram), read one candidate.
//   result stream m_*: one transfer per input transfer, carrying the live
//   candidate count, the found flag and the read-out candidate.
//   apb port: size_mode at 0x0, use_last_known at 0x4, bank_size at 0x8;
//   write only while the block is idle.
// sequence
//   snapshot: per entry a request and a capture per ram byte, then one list
//   write (two in nibble mode); the bytes pass one at a time through the
//   single shadow ram read port.
//   compare: per live candidate a list read and capture, a request and a
//   capture per ram byte, then the relation test.
//   one item is in work at a time; s_tready is low while it runs.
// reset clears the candidate count and loads the register defaults; the two
//   memories are not cleared. a stalled result is held in the output register
//   while the next item is already taken and worked on.
module memory_value_search_filter_unit #(
    parameter int RAM_BYTES  = 65536,
    parameter int CAND_DEPTH = 131072
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: ram_addr[15:0], ram_data[23:16], compare_kind[26:24],
    //        test_value[58:27], cand_index[75:59], zero fill
    input  logic [79:0] s_tdata,
    // tuser: func[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: cand_count[17:0], found[18], out_addr[34:19], out_upper[35],
    //        out_value[67:36], zero fill
    output logic [71:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mvsf_pkg::*;

    localparam int AW  = $clog2(RAM_BYTES);
    localparam int CW  = $clog2(CAND_DEPTH);
    localparam int NW  = CW + 1;
    localparam int DW  = AW + 1 + 32;
    // snapshot length cap
    localparam int LIM = (RAM_BYTES < CAND_DEPTH / 2) ? RAM_BYTES : CAND_DEPTH / 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BREQ,
        ST_BCAP,
        ST_SNAP_WR,
        ST_SNAP_WR_HI,
        ST_CMP_RD,
        ST_CMP_CAP,
        ST_CMP_EVAL,
        ST_READ_CAP,
        ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [1:0]  size_mode_reg;
    logic        use_last_reg;
    logic [16:0] bank_size_reg;
    logic [1:0]  list_mode_reg;

    // latched operands
    logic [2:0]  kind_reg;
    logic [31:0] test_reg;

    // sequencer state
    logic [NW-1:0] live_count_reg;
    logic [NW-1:0] idx_reg;
    logic [NW-1:0] kept_reg;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] total_reg;
    logic [AW-1:0] base_reg;
    logic [1:0]    k_reg;
    logic [31:0]   acc_reg;
    logic          is_cmp_reg;
    logic          ent_upper_reg;
    logic [31:0]   ent_value_reg;

    // result being built
    logic          res_found_reg;
    logic [15:0]   res_addr_reg;
    logic          res_upper_reg;
    logic [31:0]   res_value_reg;

    logic          m_tvalid_reg;
    logic [71:0]   m_tdata_reg;

    // input fields
    logic [15:0] in_ram_addr;
    logic [7:0]  in_ram_data;
    logic [2:0]  in_kind;
    logic [31:0] in_test;
    logic [16:0] in_index;
    logic        in_xfer;

    assign in_ram_addr = s_tdata[15:0];
    assign in_ram_data = s_tdata[23:16];
    assign in_kind     = s_tdata[26:24];
    assign in_test     = s_tdata[58:27];
    assign in_index    = s_tdata[75:59];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // apb
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_SIZE_MODE: prdata = {30'd0, size_mode_reg};
            REG_USE_LAST:  prdata = {31'd0, use_last_reg};
            REG_BANK_SIZE: prdata = {15'd0, bank_size_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // snapshot length and entry counts
    logic [31:0]   bank_ext;
    logic [NW-1:0] snap_n;
    logic [NW-1:0] snap_cnt;
    logic [NW-1:0] snap_total;

    assign bank_ext   = {15'd0, bank_size_reg};
    assign snap_n     = (bank_ext > 32'(LIM)) ? NW'(LIM) : NW'(bank_ext);
    assign snap_cnt   = snap_n >> step_shift(size_mode_reg);
    assign snap_total = (size_mode_reg == MODE_NIBBLE) ? NW'(snap_n << 1) : snap_cnt;

    // read-out range check
    logic idx_ok;
    assign idx_ok = (32'(in_index) < 32'(live_count_reg));

    // shadow ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_q;

    assign ram_we    = in_xfer && (s_tuser == FUNC_WRITE);
    assign ram_waddr = AW'(in_ram_addr);
    assign ram_re    = (state_reg == ST_BREQ);
    assign ram_raddr = base_reg + AW'(k_reg);  // wraps at the ram size

    mvsf_shadow_ram #(.AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_ram_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // live value of the entry just fetched
    logic [31:0] live_val;
    always_comb begin
        if (list_mode_reg == MODE_NIBBLE) begin
            live_val = ent_upper_reg ? {28'd0, acc_reg[7:4]} : {28'd0, acc_reg[3:0]};
        end else begin
            live_val = acc_reg;
        end
    end

    logic rel_pass;
    mvsf_rel_unit u_rel (
        .kind (kind_reg),
        .x    (live_val),
        .y    (use_last_reg ? ent_value_reg : test_reg),
        .pass (rel_pass)
    );

    // candidate store ports
    logic          cs_we;
    logic [CW-1:0] cs_waddr;
    logic [DW-1:0] cs_wdata;
    logic          cs_re;
    logic [CW-1:0] cs_raddr;
    logic [DW-1:0] cs_q;
    logic [NW:0]   slot2;

    assign slot2 = {idx_reg, 1'b0};

    always_comb begin
        cs_we    = 1'b0;
        cs_waddr = idx_reg[CW-1:0];
        cs_wdata = {base_reg, 1'b0, acc_reg};
        unique case (state_reg)
            ST_SNAP_WR: begin
                cs_we = 1'b1;
                if (list_mode_reg == MODE_NIBBLE) begin
                    cs_waddr = slot2[CW-1:0];
                    cs_wdata = {base_reg, 1'b0, 28'd0, acc_reg[3:0]};
                end
            end
            ST_SNAP_WR_HI: begin
                cs_we    = 1'b1;
                cs_waddr = slot2[CW-1:0] | CW'(1);
                cs_wdata = {base_reg, 1'b1, 28'd0, acc_reg[7:4]};
            end
            ST_CMP_EVAL: begin
                // survivors packed to the front, never past the read point
                cs_we    = rel_pass;
                cs_waddr = kept_reg[CW-1:0];
                cs_wdata = {base_reg, ent_upper_reg, live_val};
            end
            default: ;
        endcase
    end

    assign cs_re    = (state_reg == ST_CMP_RD) ||
                      (in_xfer && (s_tuser == FUNC_READ) && idx_ok);
    assign cs_raddr = (state_reg == ST_CMP_RD) ? idx_reg[CW-1:0] : CW'(in_index);

    mvsf_cand_store #(.CW(CW), .DW(DW)) u_cand (
        .aclk  (aclk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (cs_wdata),
        .re    (cs_re),
        .raddr (cs_raddr),
        .rdata (cs_q)
    );

    logic [NW-1:0] kept_inc;
    assign kept_inc = kept_reg + NW'(rel_pass);

    // finished result moves into the output register once it is free
    logic out_load;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            size_mode_reg  <= SIZE_MODE_RST;
            use_last_reg   <= USE_LAST_RST;
            bank_size_reg  <= BANK_SIZE_RST;
            list_mode_reg  <= SIZE_MODE_RST;
            live_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_SIZE_MODE: size_mode_reg <= pwdata[1:0];
                    REG_USE_LAST:  use_last_reg  <= pwdata[0];
                    REG_BANK_SIZE: bank_size_reg <= pwdata[16:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        kind_reg      <= in_kind;
                        test_reg      <= in_test;
                        res_found_reg <= 1'b0;
                        res_addr_reg  <= '0;
                        res_upper_reg <= 1'b0;
                        res_value_reg <= '0;
                        idx_reg       <= '0;
                        kept_reg      <= '0;
                        k_reg         <= '0;
                        acc_reg       <= '0;
                        base_reg      <= '0;
                        ent_upper_reg <= 1'b0;
                        unique case (s_tuser)
                            FUNC_WRITE: state_reg <= ST_DONE;
                            FUNC_SNAP: begin
                                list_mode_reg <= size_mode_reg;
                                cnt_reg       <= snap_cnt;
                                total_reg     <= snap_total;
                                is_cmp_reg    <= 1'b0;
                                if (snap_cnt == '0) begin
                                    live_count_reg <= '0;
                                    state_reg      <= ST_DONE;
                                end else begin
                                    state_reg <= ST_BREQ;
                                end
                            end
                            FUNC_CMP: begin
                                is_cmp_reg <= 1'b1;
                                state_reg  <= (live_count_reg == '0) ? ST_DONE : ST_CMP_RD;
                            end
                            FUNC_READ: begin
                                state_reg <= idx_ok ? ST_READ_CAP : ST_DONE;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_BREQ: state_reg <= ST_BCAP;
                ST_BCAP: begin
                    acc_reg[8*k_reg +: 8] <= ram_q;
                    if (k_reg == last_byte(list_mode_reg)) begin
                        state_reg <= is_cmp_reg ? ST_CMP_EVAL : ST_SNAP_WR;
                    end else begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_BREQ;
                    end
                end
                ST_SNAP_WR, ST_SNAP_WR_HI: begin
                    if (state_reg == ST_SNAP_WR && list_mode_reg == MODE_NIBBLE) begin
                        state_reg <= ST_SNAP_WR_HI;
                    end else if (idx_reg + NW'(1) == cnt_reg) begin
                        live_count_reg <= total_reg;
                        state_reg      <= ST_DONE;
                    end else begin
                        idx_reg   <= idx_reg + NW'(1);
                        base_reg  <= AW'((idx_reg + NW'(1)) << step_shift(list_mode_reg));
                        k_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_BREQ;
                    end
                end
                ST_CMP_RD: state_reg <= ST_CMP_CAP;
                ST_CMP_CAP: begin
                    base_reg      <= cs_q[DW-1 -: AW];
                    ent_upper_reg <= cs_q[32];
                    ent_value_reg <= cs_q[31:0];
                    k_reg         <= '0;
                    acc_reg       <= '0;
                    state_reg     <= ST_BREQ;
                end
                ST_CMP_EVAL: begin
                    kept_reg <= kept_inc;
                    if (idx_reg + NW'(1) == live_count_reg) begin
                        // an empty filter leaves the list as it was
                        if (kept_inc != '0) begin
                            live_count_reg <= kept_inc;
                        end
                        res_found_reg <= (kept_inc != '0);
                        state_reg     <= ST_DONE;
                    end else begin
                        idx_reg   <= idx_reg + NW'(1);
                        state_reg <= ST_CMP_RD;
                    end
                end
                ST_READ_CAP: begin
                    res_addr_reg  <= 16'(cs_q[DW-1 -: AW]);
                    res_upper_reg <= cs_q[32];
                    res_value_reg <= cs_q[31:0];
                    state_reg     <= ST_DONE;
                end
                ST_DONE: begin
                    // load the output register once it is free
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, res_value_reg, res_upper_reg, res_addr_reg,
                                         res_found_reg, 18'(live_count_reg)};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // found never reported with an empty list
    a_found_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[18] || (m_tdata[17:0] != 18'd0)))
        else $error("found flag with zero candidates");

    // count never exceeds the store depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(live_count_reg) <= 32'(CAND_DEPTH))
        else $error("candidate count beyond store depth");

    // compaction write point never passes the read point
    a_kept_le_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP_EVAL) |-> (kept_reg <= idx_reg))
        else $error("compaction overtook the scan");

    // an accepted item always leads to a busy input side next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice in a row");

endmodule

### verif/memory_value_search_filter_unit_tb.sv
// self-checking testbench for memory_value_search_filter_unit: queue-fed stream driver,
// stream monitor, apb register writes and a cycle-free predictor of the candidate list
// depends on mvsf_pkg and the rtl of memory_value_search_filter_unit
module memory_value_search_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mvsf_pkg::*;

    typedef struct {
        func_t       func;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [2:0]  kind;
        logic [31:0] test;
        logic [16:0] idx;
    } op_t;

    typedef struct packed {
        logic [17:0] cnt;
        logic        found;
        logic [15:0] addr;
        logic        upper;
        logic [31:0] value;
    } res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    memory_value_search_filter_unit dut (.*);

    // predicted block state
    logic [7:0]  ram_img [65536];
    logic [15:0] cl_addr [131072];
    logic        cl_upper [131072];
    logic [31:0] cl_value [131072];
    logic [17:0] cl_count = '0;
    logic [1:0]  cl_mode = SIZE_MODE_RST;
    logic [1:0]  r_size_mode = SIZE_MODE_RST;
    logic        r_use_last = USE_LAST_RST;
    logic [16:0] r_bank = BANK_SIZE_RST;

    op_t  pending_ops [$];
    res_t awaited_res [$];
    op_t  cur_op;
    int   n_errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_seq = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // runaway guard, far beyond the slowest legal run
    initial begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [31:0] live_val(logic [1:0] mode, logic [15:0] a, logic up);
        logic [7:0] b;
        b = ram_img[a];
        case (mode)
            MODE_NIBBLE: return up ? {28'd0, b[7:4]} : {28'd0, b[3:0]};
            MODE_BYTE:   return {24'd0, b};
            MODE_HALF:   return {16'd0, ram_img[a + 16'd1], b};
            default:     return {ram_img[a + 16'd3], ram_img[a + 16'd2],
                                 ram_img[a + 16'd1], b};
        endcase
    endfunction

    function automatic logic holds(logic [2:0] kind, logic [31:0] x, logic [31:0] y);
        case (kind)
            REL_EQ:  return x == y;
            REL_LT:  return x < y;
            REL_LE:  return x <= y;
            REL_GT:  return x > y;
            REL_GE:  return x >= y;
            REL_NE:  return x != y;
            default: return 1'b0;
        endcase
    endfunction

    // rebuild the candidate list from the shadow image
    task automatic take_snapshot();
        int n;
        int stp;
        n = (r_bank > 65536) ? 65536 : r_bank;
        cl_mode = r_size_mode;
        if (cl_mode == MODE_NIBBLE) begin
            for (int i = 0; i < n; i++) begin
                cl_addr[2*i] = i;
                cl_upper[2*i] = 1'b0;
                cl_value[2*i] = live_val(MODE_NIBBLE, i, 1'b0);
                cl_addr[2*i+1] = i;
                cl_upper[2*i+1] = 1'b1;
                cl_value[2*i+1] = live_val(MODE_NIBBLE, i, 1'b1);
            end
            cl_count = 2 * n;
        end else begin
            stp = 1 << step_shift(cl_mode);
            for (int i = 0; i < n / stp; i++) begin
                cl_addr[i] = i * stp;
                cl_upper[i] = 1'b0;
                cl_value[i] = live_val(cl_mode, i * stp, 1'b0);
            end
            cl_count = n / stp;
        end
    endtask

    // filter and compact the list, survivors take the live value
    function automatic logic filter_list(logic [2:0] kind, logic [31:0] test);
        int kept;
        logic [31:0] v;
        logic [31:0] ref_v;
        kept = 0;
        for (int i = 0; i < cl_count; i++) begin
            v = live_val(cl_mode, cl_addr[i], cl_upper[i]);
            ref_v = r_use_last ? cl_value[i] : test;
            if (holds(kind, v, ref_v)) begin
                cl_value[kept] = v;
                cl_addr[kept] = cl_addr[i];
                cl_upper[kept] = cl_upper[i];
                kept++;
            end
        end
        if (kept > 0) cl_count = kept;
        return kept > 0;
    endfunction

    task automatic predict_op(op_t op);
        res_t r;
        r = '0;
        case (op.func)
            FUNC_WRITE: ram_img[op.addr] = op.data;
            FUNC_SNAP:  take_snapshot();
            FUNC_CMP:   r.found = filter_list(op.kind, op.test);
            default: begin
                if (op.idx < cl_count) begin
                    r.addr = cl_addr[op.idx];
                    r.upper = cl_upper[op.idx];
                    r.value = cl_value[op.idx];
                end
            end
        endcase
        r.cnt = cl_count;
        awaited_res.push_back(r);
    endtask

    // monitor first, then the input transfer of the same edge
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.cnt = m_tdata[17:0];
            got.found = m_tdata[18];
            got.addr = m_tdata[34:19];
            got.upper = m_tdata[35];
            got.value = m_tdata[67:36];
            if (awaited_res.size() == 0) begin
                n_errors++;
                $display("%0t: mismatch expected none actual %p", $realtime, got);
            end else begin
                want = awaited_res.pop_front();
                if (got != want) begin
                    n_errors++;
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            predict_op(cur_op);
        end
    end

    // a transfer happened at the last rising edge
    logic s_took = 1'b0;
    always @(posedge aclk) s_took <= s_tvalid & s_tready;

    // stream driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_op = pending_ops.pop_front();
                s_tuser <= cur_op.func;
                // zero fill, cand_index, test_value, compare_kind, ram_data, ram_addr
                s_tdata <= {4'd0, cur_op.idx, cur_op.test, cur_op.kind,
                            cur_op.data, cur_op.addr};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and long hold-offs on request
    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_op(func_t f, logic [15:0] a, logic [7:0] d, logic [2:0] k,
                            logic [31:0] t, logic [16:0] ix);
        op_t op;
        op.func = f;
        op.addr = a;
        op.data = d;
        op.kind = k;
        op.test = t;
        op.idx = ix;
        pending_ops.push_back(op);
    endtask

    // block is idle once every transfer is back, plus some margin
    task automatic drain();
        while (pending_ops.size() > 0 || s_tvalid || awaited_res.size() > 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // apb write: setup then access, register updates in the predictor too
    task automatic reg_write(logic [1:0] ri, logic [31:0] v);
        @(negedge aclk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {ri, 2'b00};
        pwdata = v;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        case (ri)
            REG_SIZE_MODE: r_size_mode = v[1:0];
            REG_USE_LAST:  r_use_last = v[0];
            REG_BANK_SIZE: r_bank = v[16:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [1:0] mode, logic last, logic [16:0] bank);
        reg_write(REG_SIZE_MODE, mode);
        reg_write(REG_USE_LAST, last);
        reg_write(REG_BANK_SIZE, bank);
    endtask

    initial begin
        int bank;
        int pick;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // low bytes that every snapshot and compare reach are written first
        for (int a = 0; a < 20; a++)
            queue_op(FUNC_WRITE, a, $urandom, $urandom, $urandom, $urandom);
        drain();

        // word mode over the written bytes, read inside and far outside the list
        set_regs(MODE_WORD, 1'b1, 17'd19);
        queue_op(FUNC_SNAP, 0, 0, 0, 0, 0);
        queue_op(FUNC_CMP, 0, 0, REL_GE, 0, 0);
        queue_op(FUNC_READ, 0, 0, 0, 0, 17'd3);
        queue_op(FUNC_READ, 0, 0, 0, 0, 17'h1ffff);
        drain();

        // directed: smallest bank, extreme data and addresses, every relation
        set_regs(MODE_NIBBLE, 1'b0, 17'd4);
        queue_op(FUNC_WRITE, 16'hffff, 8'hff, 0, 0, 0);
        queue_op(FUNC_WRITE, 16'h0000, 8'h00, 0, 0, 0);
        queue_op(FUNC_WRITE, 16'h0001, 8'hf0, 0, 0, 0);
        queue_op(FUNC_SNAP, 0, 0, 0, 0, 0);
        queue_op(FUNC_READ, 0, 0, 0, 0, 17'd0);
        queue_op(FUNC_READ, 0, 0, 0, 0, 17'd7);
        queue_op(FUNC_READ, 0, 0, 0, 0, 17'd8);
        queue_op(FUNC_CMP, 0, 0, 3'd6, 32'd0, 0);
        queue_op(FUNC_CMP, 0, 0, 3'd7, 32'hffffffff, 0);
        queue_op(FUNC_CMP, 0, 0, REL_LT, 32'hffffffff, 0);
        queue_op(FUNC_CMP, 0, 0, REL_EQ, 32'h12345678, 0);
        queue_op(FUNC_CMP, 0, 0, REL_LE, 32'd15, 0);
        queue_op(FUNC_CMP, 0, 0, REL_GT, 32'd0, 0);
        queue_op(FUNC_CMP, 0, 0, REL_NE, 32'd0, 0);
        queue_op(FUNC_CMP, 0, 0, REL_GE, 32'd15, 0);
        queue_op(FUNC_READ, 0, 0, 0, 0, 17'd0);
        drain();
        // size changes after a snapshot only act at the next one
        set_regs(MODE_HALF, 1'b1, 17'd5);
        queue_op(FUNC_READ, 0, 0, 0, 0, 17'd1);
        queue_op(FUNC_SNAP, 0, 0, 0, 0, 0);
        queue_op(FUNC_WRITE, 16'h0002, 8'h7f, 0, 0, 0);
        queue_op(FUNC_CMP, 0, 0, REL_NE, 0, 0);
        queue_op(FUNC_READ, 0, 0, 0, 0, 17'd0);
        drain();

        // random phases: no idling, sender idle, receiver stalls, both
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 81 : 29) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 2) ? 81 : 29) : 0;
            bank = $urandom_range(4, 16);
            set_regs($urandom_range(3), $urandom_range(1), bank);
            queue_op(FUNC_SNAP, 0, 0, 0, 0, 0);
            for (int k = 0; k < 7; k++) begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    // mostly within the bank so compares see changes
                    queue_op(FUNC_WRITE,
                             ($urandom_range(9) == 0) ? $urandom : $urandom_range(bank + 3),
                             $urandom, $urandom, $urandom, $urandom);
                end else if (pick < 65) begin
                    queue_op(FUNC_CMP, $urandom, $urandom, $urandom_range(7),
                             ($urandom_range(1) == 1) ? $urandom_range(15) : $urandom,
                             $urandom);
                end else if (pick < 95) begin
                    queue_op(FUNC_READ, $urandom, $urandom, $urandom, $urandom,
                             ($urandom_range(7) == 0) ? $urandom : $urandom_range(2 * bank));
                end else begin
                    queue_op(FUNC_SNAP, $urandom, $urandom, $urandom, $urandom, $urandom);
                end
            end
            // long receiver hold-off while the sender keeps offering
            if (ph == 1) begin
                @(negedge aclk);
                hold_seq = hold_seq + 1;
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/mvsf_pkg.sv
rtl/mvsf_shadow_ram.sv
rtl/mvsf_cand_store.sv
rtl/mvsf_rel_unit.sv
rtl/memory_value_search_filter_unit.sv
verif/memory_value_search_filter_unit_tb.sv
